FILE: design/emd_pkg.sv
// Shared types and constants of the multi-tap feedback delay.
`timescale 1ns / 1ps
package emd_pkg;

  localparam int unsigned MaxSteps    = 24;
  localparam int unsigned CntW        = 5;
  localparam int unsigned StepSampW   = 17;
  localparam int unsigned GainW       = 16;
  localparam int unsigned MixW        = 17;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 17;
  localparam int unsigned GridW       = 2 * CntW + 1;
  localparam int unsigned DenW        = CntW + 1;
  localparam int unsigned FeedbackMax = 64225;
  localparam int unsigned GainOne     = 65536;

  localparam logic [StepSampW-1:0] StepSampRst = 17'd24000;
  localparam logic [CntW-1:0]      StepCntRst  = 5'd16;
  localparam logic [CntW-1:0]      TapNumRst   = 5'd5;
  localparam logic [CntW-1:0]      TapOffRst   = 5'd0;
  localparam logic [GainW-1:0]     FeedbackRst = 16'd22938;
  localparam logic [MixW-1:0]      MixRst      = 17'd22938;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStepSamples = 3'd0,
    CfgStepCount   = 3'd1,
    CfgTapNumber   = 3'd2,
    CfgTapOffset   = 3'd3,
    CfgFeedback    = 3'd4,
    CfgMix         = 3'd5
  } cfg_index_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StDivGo,
    StDivWait,
    StMult,
    StFinish
  } emd_state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic div_start;
    logic mult;
    logic finish;
  } emd_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_done;
    logic out_free;
  } emd_status_t;

endpackage

FILE: design/euclidean_multitap_delay.sv
// Top level of the stereo multi-tap feedback delay.
//
// A stereo frame arrives on the s_axis channel; one mixed frame leaves on
// m_axis for every input transaction. Register writes come on the cfg channel,
// which is always ready, and are meant to happen while no frame is in flight.
// Each frame scans S grid steps, where S is the clamped step count, reading
// the taps from both delay stores; then the read pipeline drains, a
// bit-serial divider forms the tap average, and a multiply state and a
// write-back state follow. After the write-back the block returns to idle
// and the next frame is accepted right after.
// A finished frame sits in an output register, so a new input can be
// accepted while it waits; the block holds in its last step only if the
// previous result was still not taken. Reset returns the registers to their
// defaults and marks the delay stores empty through the write pointer and a
// wrap flag, so no clearing pass runs and the block is ready at once.
`timescale 1ns / 1ps
module euclidean_multitap_delay
  import emd_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH = 131072,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sample_left, sample_right
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_left, out_right
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]                    cfg_index_i,
  input  logic [CfgDataW-1:0]                   cfg_data_i
);

  localparam int unsigned TDW = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  emd_cmd_t    cmd;
  emd_status_t status;

  assign cfg_ready_o = 1'b1;

  emd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  emd_dp #(
    .SB   (SAMPLE_BITS),
    .DEPTH(DELAY_DEPTH),
    .TDW  (TDW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

FILE: design/emd_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module emd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/emd_div.sv
// Restoring divider, one quotient bit per cycle, floor rounding of signed numerators.
`timescale 1ns / 1ps
module emd_div
  import emd_pkg::*;
#(
  parameter int unsigned MW = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic signed [MW:0] num_i,
  input  logic [DenW-1:0]   den_i,
  output logic              done_o,
  output logic signed [MW:0] quo_o
);

  localparam int unsigned CW = $clog2(MW + 1);

  logic [MW-1:0]   mag_q, mag_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic            neg_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;
  logic signed [MW:0] num_abs;

  assign num_abs = num_i[MW] ? -num_i : num_i;
  assign trial   = {rem_q, mag_q[MW-1]};

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      mag_d  = num_abs[MW-1:0];
      rem_d  = '0;
      cnt_d  = CW'(MW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DenW'(trial - {1'b0, den_q});
        mag_d = {mag_q[MW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        mag_d = {mag_q[MW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[MW];
    end
  end

  always_comb begin
    if (!neg_q) begin
      quo_o = $signed({1'b0, mag_q});
    end else if (rem_q != '0) begin
      quo_o = -$signed({1'b0, mag_q}) - $signed((MW + 1)'(1));
    end else begin
      quo_o = -$signed({1'b0, mag_q});
    end
  end

  assign done_o = done_q;

endmodule

FILE: design/emd_dp.sv
// Datapath: configuration registers, tap scan, delay stores, averaging and mixing.
`timescale 1ns / 1ps
module emd_dp
  import emd_pkg::*;
#(
  parameter int unsigned SB    = 24,
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned TDW   = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [TDW-1:0]      in_data_i,
  input  emd_cmd_t            cmd_i,
  output emd_status_t         status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [TDW-1:0]      out_data_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned SUMW = SB + 5;
  localparam int unsigned MW   = SB + 6;
  localparam int unsigned PW   = StepSampW + CntW;

  logic [StepSampW-1:0] step_samples_q;
  logic [CntW-1:0]      step_count_q, tap_number_q, tap_offset_q;
  logic [GainW-1:0]     feedback_q;
  logic [MixW-1:0]      mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_samples_q <= StepSampRst;
      step_count_q   <= StepCntRst;
      tap_number_q   <= TapNumRst;
      tap_offset_q   <= TapOffRst;
      feedback_q     <= FeedbackRst;
      mix_q          <= MixRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgStepSamples: step_samples_q <= cfg_data_i[StepSampW-1:0];
        CfgStepCount:   step_count_q   <= cfg_data_i[CntW-1:0];
        CfgTapNumber:   tap_number_q   <= cfg_data_i[CntW-1:0];
        CfgTapOffset:   tap_offset_q   <= cfg_data_i[CntW-1:0];
        CfgFeedback:    feedback_q     <= cfg_data_i[GainW-1:0];
        CfgMix:         mix_q          <= cfg_data_i[MixW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped pattern settings for the frame being loaded.
  logic [CntW-1:0]      s_c, t_c, o_c, p_c;
  logic [StepSampW-1:0] per_c;
  logic [GainW-1:0]     fb_c;
  logic [MixW-1:0]      mix_c, dmix_c;

  always_comb begin
    if (step_count_q < CntW'(2)) begin
      s_c = CntW'(2);
    end else if (step_count_q > CntW'(MaxSteps)) begin
      s_c = CntW'(MaxSteps);
    end else begin
      s_c = step_count_q;
    end
    if (tap_number_q == '0) begin
      t_c = CntW'(1);
    end else if (tap_number_q > s_c) begin
      t_c = s_c;
    end else begin
      t_c = tap_number_q;
    end
    o_c    = (tap_offset_q > s_c) ? s_c : tap_offset_q;
    p_c    = (o_c == s_c) ? '0 : o_c;
    per_c  = (step_samples_q == '0) ? StepSampW'(1) : step_samples_q;
    fb_c   = (feedback_q > GainW'(FeedbackMax)) ? GainW'(FeedbackMax) : feedback_q;
    mix_c  = (mix_q > MixW'(GainOne)) ? MixW'(GainOne) : mix_q;
    dmix_c = MixW'(GainOne) - mix_c;
  end

  logic [CntW-1:0]      s_q, t_q, j_q, p_q;
  logic [StepSampW-1:0] per_q;
  logic [GridW-1:0]     n_q, lim_q;
  logic [AW-1:0]        wp_q;
  logic                 wrapped_q;
  logic                 hit, rd_hit_q, rd_ok_q;
  logic [PW-1:0]        dly;
  logic [AW-1:0]        dly_c, rd_addr;
  logic [AW:0]          wrap_addr;

  assign hit       = n_q < lim_q;
  assign dly       = PW'(p_q) * PW'(per_q);
  assign dly_c     = (32'(dly) > 32'(DEPTH - 1)) ? AW'(DEPTH - 1) : AW'(dly);
  assign wrap_addr = {1'b0, wp_q} + (AW + 1)'(DEPTH) - {1'b0, dly_c};
  assign rd_addr   = (wp_q >= dly_c) ? (wp_q - dly_c) : wrap_addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q   <= s_c;
      t_q   <= t_c;
      per_q <= per_c;
      p_q   <= p_c;
      j_q   <= '0;
      n_q   <= '0;
      lim_q <= GridW'(t_c);
    end else if (cmd_i.scan) begin
      j_q   <= j_q + 1'b1;
      lim_q <= lim_q + GridW'(t_q);
      p_q   <= (p_q + 1'b1 == s_q) ? '0 : p_q + 1'b1;
      if (hit) begin
        n_q <= n_q + GridW'(s_q);
      end
    end
    rd_ok_q <= wrapped_q || (rd_addr < wp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_hit_q  <= 1'b0;
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else begin
      rd_hit_q <= cmd_i.scan && hit;
      if (cmd_i.finish) begin
        if (wp_q == AW'(DEPTH - 1)) begin
          wp_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wp_q <= wp_q + 1'b1;
        end
      end
    end
  end

  assign status_o.scan_last = (j_q == s_q - 1'b1);

  logic signed [SB-1:0]   x_l_q, x_r_q;
  logic signed [SB-1:0]   rd_l, rd_r, fed_l, fed_r, out_l, out_r;
  logic signed [SUMW-1:0] sum_l_q, sum_r_q;
  logic signed [MW:0]     num_l, num_r, quo_l, quo_r;
  logic                   done_l, done_r;
  logic [DenW-1:0]        den;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_l_q   <= $signed(in_data_i[SB-1:0]);
      x_r_q   <= $signed(in_data_i[2*SB-1:SB]);
      sum_l_q <= '0;
      sum_r_q <= '0;
    end else if (rd_hit_q && rd_ok_q) begin
      sum_l_q <= sum_l_q + SUMW'(rd_l);
      sum_r_q <= sum_r_q + SUMW'(rd_r);
    end
  end

  emd_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_ram_l (
    .clk_i  (clk_i),
    .we_i   (cmd_i.finish),
    .waddr_i(wp_q),
    .wdata_i(fed_l),
    .raddr_i(rd_addr),
    .rdata_o(rd_l)
  );

  emd_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_ram_r (
    .clk_i  (clk_i),
    .we_i   (cmd_i.finish),
    .waddr_i(wp_q),
    .wdata_i(fed_r),
    .raddr_i(rd_addr),
    .rdata_o(rd_r)
  );

  assign num_l = $signed({sum_l_q[SUMW-1], sum_l_q, 1'b0}) + $signed({(MW - CntW + 1)'(0), t_q});
  assign num_r = $signed({sum_r_q[SUMW-1], sum_r_q, 1'b0}) + $signed({(MW - CntW + 1)'(0), t_q});
  assign den   = {t_q, 1'b0};

  emd_div #(.MW(MW)) u_div_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num_l),
    .den_i  (den),
    .done_o (done_l),
    .quo_o  (quo_l)
  );

  emd_div #(.MW(MW)) u_div_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num_r),
    .den_i  (den),
    .done_o (done_r),
    .quo_o  (quo_r)
  );

  assign status_o.div_done = done_l && done_r;

  logic signed [SB+16:0] pf_l_q, pf_r_q;
  logic signed [SB+17:0] pd_l_q, pd_r_q, pw_l_q, pw_r_q;
  logic signed [SB-1:0]  wet_l, wet_r;

  assign wet_l = $signed(quo_l[SB-1:0]);
  assign wet_r = $signed(quo_r[SB-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      pf_l_q <= wet_l * $signed({1'b0, fb_c});
      pf_r_q <= wet_r * $signed({1'b0, fb_c});
      pd_l_q <= x_l_q * $signed({1'b0, dmix_c});
      pd_r_q <= x_r_q * $signed({1'b0, dmix_c});
      pw_l_q <= wet_l * $signed({1'b0, mix_c});
      pw_r_q <= wet_r * $signed({1'b0, mix_c});
    end
  end

  function automatic logic signed [SB-1:0] sat(input logic signed [SB+2:0] v);
    logic signed [SB-1:0] r;
    if ((v[SB+2:SB-1] == '0) || (v[SB+2:SB-1] == '1)) begin
      r = v[SB-1:0];
    end else if (v[SB+2]) begin
      r = {1'b1, {(SB - 1){1'b0}}};
    end else begin
      r = {1'b0, {(SB - 1){1'b1}}};
    end
    return r;
  endfunction

  logic signed [SB+17:0] fr_l, fr_r;
  logic signed [SB+18:0] mr_l, mr_r;

  assign fr_l  = (SB + 18)'(pf_l_q) + (SB + 18)'(32768);
  assign fr_r  = (SB + 18)'(pf_r_q) + (SB + 18)'(32768);
  assign fed_l = sat((SB + 3)'(fr_l >>> 16) + (SB + 3)'(x_l_q));
  assign fed_r = sat((SB + 3)'(fr_r >>> 16) + (SB + 3)'(x_r_q));
  assign mr_l  = (SB + 19)'(pd_l_q) + (SB + 19)'(pw_l_q) + (SB + 19)'(32768);
  assign mr_r  = (SB + 19)'(pd_r_q) + (SB + 19)'(pw_r_q) + (SB + 19)'(32768);
  assign out_l = sat((SB + 3)'(mr_l >>> 16));
  assign out_r = sat((SB + 3)'(mr_r >>> 16));

  logic out_valid_q;
  logic [TDW-1:0] out_data_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= TDW'({out_r, out_l});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: design/emd_ctrl.sv
// Frame sequencer: scan of the tap grid, division, multiply and write back.
`timescale 1ns / 1ps
module emd_ctrl
  import emd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  emd_status_t status_i,
  output emd_cmd_t    cmd_o
);

  emd_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (in_valid_i) state_d = StScan;
      StScan:    if (status_i.scan_last) state_d = StDrain;
      StDrain:   state_d = StDivGo;
      StDivGo:   state_d = StDivWait;
      StDivWait: if (status_i.div_done) state_d = StMult;
      StMult:    state_d = StFinish;
      StFinish:  if (status_i.out_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StScan:   cmd_o.scan = 1'b1;
      StDivGo:  cmd_o.div_start = 1'b1;
      StMult:   cmd_o.mult = 1'b1;
      StFinish: cmd_o.finish = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/emd_checker.sv
// Port-level checks of the multi-tap delay and their binding to the top level.
`timescale 1ns / 1ps
module emd_checker #(
  parameter int unsigned TDW = 48
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid,
  input logic           s_axis_tready,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [TDW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction dropped or changed while stalled");

  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second input accepted while a frame is in work");

  a_no_fast_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared right after input transaction");

  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a frame in work");

endmodule

bind euclidean_multitap_delay emd_checker #(.TDW(TDW)) u_emd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
